// ----- design/msd_pkg.sv -----
package msd_pkg;

    // Counter and field widths
    localparam int OFFSET_BITS = 24;
    localparam int INDEX_BITS  = 16;
    localparam int LEN_BITS    = 24;
    localparam int TAG_BITS    = 16;

    // Lead bytes
    localparam logic [7:0] LEAD_END    = 8'hE0;
    localparam logic [7:0] LEAD_SKIP   = 8'hE1;
    localparam logic [7:0] LEAD_TLONG  = 8'hE3;
    localparam logic [7:0] LEAD_UNTAG  = 8'hE4;
    localparam logic [7:0] LEAD_TSHORT = 8'hE5;

    // Header lengths in bytes
    localparam logic [2:0] HDR_LONG  = 3'd6;
    localparam logic [2:0] HDR_SHORT = 3'd4;

    typedef enum logic [2:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_PAYLOAD = 3'd1,
        ROLE_END     = 3'd2,
        ROLE_IGNORED = 3'd3,
        ROLE_ERROR   = 3'd4
    } t_role;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_SKIP   = 3'd1,
        KIND_TLONG  = 3'd2,
        KIND_UNTAG  = 3'd3,
        KIND_TSHORT = 3'd4,
        KIND_END    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_HEAD = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN = 2'd0,
        ST_END = 2'd1,
        ST_ERR = 2'd2
    } t_stop;

    // Classified input byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        t_kind      lead_kind;
    } t_item;

    // One labelled byte
    typedef struct packed {
        t_role                  role;
        t_kind                  kind;
        logic [TAG_BITS-1:0]    tag;
        logic [LEN_BITS-1:0]    poff;
        logic                   done;
        logic [INDEX_BITS-1:0]  eidx;
        logic [OFFSET_BITS-1:0] eoff;
        logic [OFFSET_BITS-1:0] boff;
        logic                   trunc;
    } t_result;

    // Decode a byte as a lead byte
    function automatic t_kind lead_decode(input logic [7:0] b);
        t_kind k;
        unique case (b)
            LEAD_END:    k = KIND_END;
            LEAD_SKIP:   k = KIND_SKIP;
            LEAD_TLONG:  k = KIND_TLONG;
            LEAD_UNTAG:  k = KIND_UNTAG;
            LEAD_TSHORT: k = KIND_TSHORT;
            default:     k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ----- design/marker_segment_deframer.sv -----
// Marker segment deframer: takes one byte of an object buffer per transfer and labels
// it as header, payload, end marker, ignored or error, with the segment kind, tag,
// payload offset, entry index and offset, and buffer offset. The block sustains one
// byte per clock while results are popped; each transfer writes the byte into the input
// queue, then the per-byte parser update writes its label into the result queue, from
// which it shows on the result ports. The rate is set by the parser's per-byte header
// and counter update.
// Both queues hold two entries, so the input side keeps accepting while a result
// waits to be popped. An unknown lead byte or a segment length shorter than its
// header raises a sticky error; every byte is then ignored until first_in_buffer.
module marker_segment_deframer
    import msd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_first_in_buffer,
    input  logic                   i_last_in_buffer,
    output logic                   empty,
    input  logic                   pop,
    output logic [2:0]             o_byte_role,
    output logic [2:0]             o_segment_kind,
    output logic [TAG_BITS-1:0]    o_segment_tag,
    output logic [LEN_BITS-1:0]    o_payload_offset,
    output logic                   o_segment_done,
    output logic [INDEX_BITS-1:0]  o_entry_index,
    output logic [OFFSET_BITS-1:0] o_entry_offset,
    output logic [OFFSET_BITS-1:0] o_buffer_offset,
    output logic                   o_truncated
);

    logic    item_valid;
    logic    item_take;
    t_item   item;
    t_result result;

    // Accept and classify bytes
    msd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_data_byte       (i_data_byte),
        .i_first_in_buffer (i_first_in_buffer),
        .i_last_in_buffer  (i_last_in_buffer),
        .o_full            (full),
        .o_valid           (item_valid),
        .o_item            (item),
        .i_take            (item_take)
    );

    // Parse segments and queue results
    msd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (item_valid),
        .i_item   (item),
        .o_take   (item_take),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (result)
    );

    // Unpack the result onto its ports
    assign o_byte_role      = result.role;
    assign o_segment_kind   = result.kind;
    assign o_segment_tag    = result.tag;
    assign o_payload_offset = result.poff;
    assign o_segment_done   = result.done;
    assign o_entry_index    = result.eidx;
    assign o_entry_offset   = result.eoff;
    assign o_buffer_offset  = result.boff;
    assign o_truncated      = result.trunc;

endmodule

// ----- design/msd_front.sv -----
module msd_front
    import msd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_in_buffer,
    input  logic       i_last_in_buffer,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item,
    input  logic       i_take
);

    t_item       r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    logic        n_wr;
    logic        n_rd;
    logic [1:0]  n_cnt;
    logic        wr_en;
    logic        rd_en;
    t_item       in_item;

    // Classify the incoming byte
    always_comb begin
        in_item.data      = i_data_byte;
        in_item.first     = i_first_in_buffer;
        in_item.last      = i_last_in_buffer;
        in_item.lead_kind = lead_decode(i_data_byte);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_valid;

    // Advance pointers and fill count
    always_comb begin
        n_wr  = wr_en ? ~r_wr : r_wr;
        n_rd  = rd_en ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the transfer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= in_item;
        end
    end

endmodule

// ----- design/msd_back.sv -----
module msd_back
    import msd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_take,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    // Parser state
    t_phase                 r_phase, n_phase;
    t_stop                  r_stop, n_stop;
    logic [2:0]             r_hcnt, n_hcnt;
    logic [LEN_BITS-1:0]    r_len, n_len;
    logic [LEN_BITS-1:0]    r_left, n_left;
    logic [TAG_BITS-1:0]    r_tag, n_tag;
    t_kind                  r_kind, n_kind;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [INDEX_BITS-1:0]  r_ecnt, n_ecnt;
    logic [OFFSET_BITS-1:0] r_start, n_start;

    // State seen by this byte, after a buffer restart
    t_phase                 e_phase;
    t_stop                  e_stop;
    logic [2:0]             e_hcnt;
    logic [LEN_BITS-1:0]    e_len;
    logic [LEN_BITS-1:0]    e_left;
    logic [TAG_BITS-1:0]    e_tag;
    t_kind                  e_kind;
    logic [OFFSET_BITS-1:0] e_pos;
    logic [INDEX_BITS-1:0]  e_ecnt;
    logic [OFFSET_BITS-1:0] e_start;

    logic [7:0]             b;
    logic [2:0]             hl;
    logic [3:0]             idx_inc;
    logic [LEN_BITS-1:0]    h_len;
    logic [TAG_BITS-1:0]    h_tag;
    logic                   seg_lead;
    logic                   short_err;
    logic                   hdr_end;
    logic                   body_end;
    t_phase                 p_phase;
    t_stop                  p_stop;
    t_result                res;

    // Result queue
    t_result                r_oq [2];
    logic                   r_owr, r_ord;
    logic [1:0]             r_ocnt;
    logic                   o_wr_en, o_rd_en;

    assign o_take  = i_valid && (r_ocnt != 2'd2);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_result = r_oq[r_ord];
    assign o_wr_en = o_take;
    assign o_rd_en = i_pop && !o_empty;

    // Restart at offset zero on the first byte of a buffer
    always_comb begin
        if (i_item.first) begin
            e_phase = PH_LEAD;
            e_stop  = ST_RUN;
            e_hcnt  = '0;
            e_len   = '0;
            e_left  = '0;
            e_tag   = '0;
            e_kind  = KIND_NONE;
            e_pos   = '0;
            e_ecnt  = '0;
            e_start = '0;
        end else begin
            e_phase = r_phase;
            e_stop  = r_stop;
            e_hcnt  = r_hcnt;
            e_len   = r_len;
            e_left  = r_left;
            e_tag   = r_tag;
            e_kind  = r_kind;
            e_pos   = r_pos;
            e_ecnt  = r_ecnt;
            e_start = r_start;
        end
    end

    assign b        = i_item.data;
    assign hl       = (e_kind == KIND_TLONG) ? HDR_LONG : HDR_SHORT;
    assign idx_inc  = {1'b0, e_hcnt} + 4'd1;
    assign seg_lead = (i_item.lead_kind == KIND_SKIP) || (i_item.lead_kind == KIND_TLONG)
                   || (i_item.lead_kind == KIND_UNTAG) || (i_item.lead_kind == KIND_TSHORT);

    // Merge one header byte into length and tag
    always_comb begin
        h_len = e_len;
        h_tag = e_tag;
        if (e_kind == KIND_TSHORT) begin
            unique case (e_hcnt)
                3'd1:    h_len = {{(LEN_BITS-8){1'b0}}, b};
                3'd2:    h_tag = {8'd0, b};
                default: h_tag = {b, e_tag[7:0]};
            endcase
        end else begin
            unique case (e_hcnt)
                3'd1:    h_len = {b, 16'd0};
                3'd2:    h_len = {e_len[23:16], b, 8'd0};
                3'd3:    h_len = {e_len[23:8], b};
                3'd4:    h_tag = {8'd0, b};
                default: h_tag = {b, e_tag[7:0]};
            endcase
        end
    end

    assign short_err = (((e_kind == KIND_TSHORT) && (e_hcnt == 3'd1))
                     || ((e_kind != KIND_TSHORT) && (e_hcnt == 3'd3)))
                     && (h_len < LEN_BITS'(hl));
    assign hdr_end   = idx_inc >= {1'b0, hl};
    assign body_end  = (e_left <= LEN_BITS'(1));

    // Next phase and stop state, before the end-of-buffer check
    always_comb begin
        p_phase = e_phase;
        p_stop  = e_stop;
        if (e_stop == ST_RUN) begin
            unique case (e_phase)
                PH_LEAD: begin
                    if (seg_lead) begin
                        p_phase = PH_HEAD;
                    end else if (i_item.lead_kind == KIND_END) begin
                        p_stop = ST_END;
                    end else begin
                        p_stop = ST_ERR;
                    end
                end
                PH_HEAD: begin
                    if (short_err) begin
                        p_stop = ST_ERR;
                    end else if (hdr_end) begin
                        p_phase = (h_len == LEN_BITS'(hl)) ? PH_LEAD : PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (body_end) begin
                        p_phase = PH_LEAD;
                    end
                end
                default: p_phase = e_phase;
            endcase
        end
        n_phase = p_phase;
        n_stop  = (i_item.last && p_stop == ST_RUN) ? ST_END : p_stop;
    end

    // Datapath registers and the labelled result
    always_comb begin
        n_hcnt  = e_hcnt;
        n_len   = e_len;
        n_left  = e_left;
        n_tag   = e_tag;
        n_kind  = e_kind;
        n_ecnt  = e_ecnt;
        n_start = e_start;
        n_pos   = (e_pos != {OFFSET_BITS{1'b1}}) ? e_pos + OFFSET_BITS'(1) : e_pos;

        res       = '0;
        res.role  = ROLE_IGNORED;
        res.kind  = KIND_NONE;
        res.boff  = e_pos;

        if (e_stop == ST_RUN) begin
            unique case (e_phase)
                PH_LEAD: begin
                    if (seg_lead) begin
                        res.role = ROLE_HEADER;
                        res.kind = i_item.lead_kind;
                        n_kind   = i_item.lead_kind;
                        n_len    = '0;
                        n_tag    = '0;
                        n_hcnt   = 3'd1;
                        if (i_item.lead_kind != KIND_SKIP) begin
                            if (e_ecnt != {INDEX_BITS{1'b1}}) begin
                                n_ecnt = e_ecnt + INDEX_BITS'(1);
                            end
                            n_start = e_pos;
                        end
                    end else if (i_item.lead_kind == KIND_END) begin
                        res.role = ROLE_END;
                        res.kind = KIND_END;
                        res.done = 1'b1;
                    end else begin
                        res.role = ROLE_ERROR;
                    end
                end
                PH_HEAD: begin
                    res.kind = e_kind;
                    n_len    = h_len;
                    n_tag    = h_tag;
                    if (short_err) begin
                        res.role = ROLE_ERROR;
                    end else begin
                        res.role = ROLE_HEADER;
                        if (hdr_end) begin
                            n_hcnt = 3'd0;
                            if (h_len == LEN_BITS'(hl)) begin
                                res.done = 1'b1;
                            end else begin
                                n_left = h_len - LEN_BITS'(hl);
                            end
                        end else begin
                            n_hcnt = idx_inc[2:0];
                        end
                    end
                end
                PH_BODY: begin
                    res.role = ROLE_PAYLOAD;
                    res.kind = e_kind;
                    res.poff = e_len - LEN_BITS'(hl) - e_left;
                    if (e_left != '0) begin
                        n_left = e_left - LEN_BITS'(1);
                    end
                    res.done = body_end;
                end
                default: res.role = ROLE_IGNORED;
            endcase
        end

        // Entry index for indexed segments; tag on tagged ones once complete
        if (((res.role == ROLE_HEADER) || (res.role == ROLE_PAYLOAD))
            && ((res.kind == KIND_TLONG) || (res.kind == KIND_UNTAG)
                || (res.kind == KIND_TSHORT))) begin
            res.eidx = n_ecnt;
            res.eoff = n_start;
            if (((res.kind == KIND_TLONG) || (res.kind == KIND_TSHORT))
                && ((res.role == ROLE_PAYLOAD)
                    || ((e_phase == PH_HEAD) && (idx_inc == {1'b0, hl})))) begin
                res.tag = n_tag;
            end
        end

        res.trunc = i_item.last && (p_stop == ST_RUN) && (p_phase != PH_LEAD);
    end

    // Commit state per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_stop  <= ST_RUN;
            r_hcnt  <= '0;
            r_len   <= '0;
            r_left  <= '0;
            r_tag   <= '0;
            r_kind  <= KIND_NONE;
            r_pos   <= '0;
            r_ecnt  <= '0;
            r_start <= '0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_stop  <= n_stop;
            r_hcnt  <= n_hcnt;
            r_len   <= n_len;
            r_left  <= n_left;
            r_tag   <= n_tag;
            r_kind  <= n_kind;
            r_pos   <= n_pos;
            r_ecnt  <= n_ecnt;
            r_start <= n_start;
        end
    end

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            r_owr  <= o_wr_en ? ~r_owr : r_owr;
            r_ord  <= o_rd_en ? ~r_ord : r_ord;
            r_ocnt <= r_ocnt + {1'b0, o_wr_en} - {1'b0, o_rd_en};
        end
    end

    // Hold the result until popped
    always_ff @(posedge i_clk) begin
        if (o_wr_en) begin
            r_oq[r_owr] <= res;
        end
    end

endmodule

// ----- design/msd_checker.sv -----
module msd_checker
    import msd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   push,
    input logic                   full,
    input logic                   empty,
    input logic                   pop,
    input logic [2:0]             o_byte_role,
    input logic [2:0]             o_segment_kind,
    input logic [TAG_BITS-1:0]    o_segment_tag,
    input logic [LEN_BITS-1:0]    o_payload_offset,
    input logic                   o_segment_done,
    input logic [INDEX_BITS-1:0]  o_entry_index,
    input logic [OFFSET_BITS-1:0] o_entry_offset,
    input logic [OFFSET_BITS-1:0] o_buffer_offset,
    input logic                   o_truncated
);

    // Queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // A waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_byte_role) && $stable(o_buffer_offset)))
        else $error("waiting result changed before pop");

    // Ignored bytes carry no segment information
    a_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_role == ROLE_IGNORED) |->
        (o_segment_kind == KIND_NONE && o_segment_tag == '0 && o_entry_index == '0
         && o_segment_done == 1'b0 && o_truncated == 1'b0))
        else $error("ignored byte carries segment fields");

    // Payload bytes belong to a real segment
    a_payload_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_byte_role == ROLE_PAYLOAD) |->
        (o_segment_kind != KIND_NONE && o_segment_kind != KIND_END))
        else $error("payload byte outside a segment");

    // Entry offset only with an entry index
    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_entry_index == '0) |-> (o_entry_offset == '0))
        else $error("entry offset without entry index");

endmodule

bind marker_segment_deframer msd_checker u_msd_checker (.*);

// ----- bench/tb_marker_segment_deframer.sv -----
`timescale 1ns / 100ps

module tb_marker_segment_deframer;
    import msd_pkg::*;

    localparam int ITEM_TARGET = 1450;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 240;
    localparam int HOLD_AFTER  = 400;
    localparam int REPORT_MAX  = 60;

    // Expected byte labels: tracks the deframer state and holds pending labels
    class byte_label_board;
        t_phase                 phase;
        logic [2:0]             hcount;
        logic [LEN_BITS-1:0]    seg_len;
        logic [LEN_BITS-1:0]    left;
        logic [TAG_BITS-1:0]    cur_tag;
        t_kind                  cur_kind;
        logic [OFFSET_BITS-1:0] pos;
        logic [INDEX_BITS-1:0]  entries;
        logic [OFFSET_BITS-1:0] start;
        t_stop                  stop;
        t_result                label_q[$];
        int                     fails;
        int                     noted;

        function new();
            fails = 0;
            noted = 0;
            clear();
        endfunction

        function void clear();
            phase    = PH_LEAD;
            hcount   = '0;
            seg_len  = '0;
            left     = '0;
            cur_tag  = '0;
            cur_kind = KIND_NONE;
            pos      = '0;
            entries  = '0;
            start    = '0;
            stop     = ST_RUN;
        endfunction

        function int header_len(t_kind k);
            return (k == KIND_TLONG) ? int'(HDR_LONG) : int'(HDR_SHORT);
        endfunction

        // Work out the label of one accepted byte and advance the parser state
        function void note_byte(logic [7:0] b, logic first, logic last);
            t_result r;
            int      idx;
            int      hl;
            r      = '0;
            r.role = ROLE_IGNORED;
            r.kind = KIND_NONE;
            idx    = 0;
            noted++;
            if (first)
                clear();
            r.boff = pos;
            if (pos != '1)
                pos++;

            if (stop != ST_RUN) begin
                r.role = ROLE_IGNORED;
            end else if (phase == PH_LEAD) begin
                r.role = ROLE_HEADER;
                case (b)
                    LEAD_END: begin
                        r.role = ROLE_END;
                        r.kind = KIND_END;
                        r.done = 1'b1;
                        stop   = ST_END;
                    end
                    LEAD_SKIP:   r.kind = KIND_SKIP;
                    LEAD_TLONG:  r.kind = KIND_TLONG;
                    LEAD_UNTAG:  r.kind = KIND_UNTAG;
                    LEAD_TSHORT: r.kind = KIND_TSHORT;
                    default: begin
                        r.role = ROLE_ERROR;
                        stop   = ST_ERR;
                    end
                endcase
                if (r.role == ROLE_HEADER) begin
                    cur_kind = r.kind;
                    seg_len  = '0;
                    cur_tag  = '0;
                    hcount   = 3'd1;
                    phase    = PH_HEAD;
                    if (r.kind != KIND_SKIP) begin
                        if (entries != '1)
                            entries++;
                        start = r.boff;
                    end
                end
            end else if (phase == PH_HEAD) begin
                r.role = ROLE_HEADER;
                r.kind = cur_kind;
                idx    = int'(hcount);
                hl     = header_len(cur_kind);
                // Collect length and tag bytes by header position
                if (cur_kind == KIND_TSHORT) begin
                    case (idx)
                        1:       seg_len = {16'h0, b};
                        2:       cur_tag = {8'h0, b};
                        default: cur_tag[15:8] = b;
                    endcase
                end else begin
                    case (idx)
                        1:       seg_len[23:16] = b;
                        2:       seg_len[15:8] = b;
                        3:       seg_len[7:0] = b;
                        4:       cur_tag = {8'h0, b};
                        default: cur_tag[15:8] = b;
                    endcase
                end
                // Length complete: it must cover the header
                if ((cur_kind == KIND_TSHORT && idx == 1) ||
                    (cur_kind != KIND_TSHORT && idx == 3)) begin
                    if (int'(seg_len) < hl) begin
                        r.role = ROLE_ERROR;
                        stop   = ST_ERR;
                    end
                end
                if (r.role == ROLE_HEADER) begin
                    if (idx + 1 >= hl) begin
                        if (int'(seg_len) == hl) begin
                            r.done = 1'b1;
                            phase  = PH_LEAD;
                        end else begin
                            left  = LEN_BITS'(seg_len - hl);
                            phase = PH_BODY;
                        end
                        hcount = '0;
                    end else begin
                        hcount = 3'(idx + 1);
                    end
                end
            end else begin
                r.role = ROLE_PAYLOAD;
                r.kind = cur_kind;
                hl     = header_len(cur_kind);
                r.poff = LEN_BITS'(seg_len - hl - left);
                if (left != '0)
                    left--;
                if (left == '0) begin
                    r.done = 1'b1;
                    phase  = PH_LEAD;
                end
            end

            // Indexed segments show their entry; tagged ones their tag
            if ((r.role == ROLE_HEADER || r.role == ROLE_PAYLOAD) &&
                (r.kind == KIND_TLONG || r.kind == KIND_UNTAG || r.kind == KIND_TSHORT)) begin
                r.eidx = entries;
                r.eoff = start;
                if ((r.kind == KIND_TLONG || r.kind == KIND_TSHORT) &&
                    (r.role == ROLE_PAYLOAD || idx + 1 == header_len(r.kind)))
                    r.tag = cur_tag;
            end

            if (last && stop == ST_RUN) begin
                r.trunc = (phase != PH_LEAD);
                stop    = ST_END;
            end
            label_q.push_back(r);
        endfunction

        function void flag(string what, logic [31:0] e, logic [31:0] a);
            fails++;
            if (fails <= REPORT_MAX)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, e, a);
        endfunction

        // Compare one popped label with the oldest pending one
        function void check_label(t_result got);
            t_result e;
            if (label_q.size() == 0) begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("%0t: unexpected result: expected none, got role %0h boff %0h",
                             $time, got.role, got.boff);
                return;
            end
            e = label_q.pop_front();
            if (e.role !== got.role)   flag("byte_role", e.role, got.role);
            if (e.kind !== got.kind)   flag("segment_kind", e.kind, got.kind);
            if (e.tag !== got.tag)     flag("segment_tag", e.tag, got.tag);
            if (e.poff !== got.poff)   flag("payload_offset", e.poff, got.poff);
            if (e.done !== got.done)   flag("segment_done", e.done, got.done);
            if (e.eidx !== got.eidx)   flag("entry_index", e.eidx, got.eidx);
            if (e.eoff !== got.eoff)   flag("entry_offset", e.eoff, got.eoff);
            if (e.boff !== got.boff)   flag("buffer_offset", e.boff, got.boff);
            if (e.trunc !== got.trunc) flag("truncated", e.trunc, got.trunc);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [7:0]             i_data_byte = 8'h00;
    logic                   i_first_in_buffer = 1'b0;
    logic                   i_last_in_buffer = 1'b0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [2:0]             o_byte_role;
    logic [2:0]             o_segment_kind;
    logic [TAG_BITS-1:0]    o_segment_tag;
    logic [LEN_BITS-1:0]    o_payload_offset;
    logic                   o_segment_done;
    logic [INDEX_BITS-1:0]  o_entry_index;
    logic [OFFSET_BITS-1:0] o_entry_offset;
    logic [OFFSET_BITS-1:0] o_buffer_offset;
    logic                   o_truncated;

    byte_label_board board;
    logic [7:0]      frame_q[$];
    t_result         seen;
    int              hold_left = 0;
    bit              hold_done = 1'b0;
    int              stall_cycles = 0;

    marker_segment_deframer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_data_byte       (i_data_byte),
        .i_first_in_buffer (i_first_in_buffer),
        .i_last_in_buffer  (i_last_in_buffer),
        .empty             (empty),
        .pop               (pop),
        .o_byte_role       (o_byte_role),
        .o_segment_kind    (o_segment_kind),
        .o_segment_tag     (o_segment_tag),
        .o_payload_offset  (o_payload_offset),
        .o_segment_done    (o_segment_done),
        .o_entry_index     (o_entry_index),
        .o_entry_offset    (o_entry_offset),
        .o_buffer_offset   (o_buffer_offset),
        .o_truncated       (o_truncated)
    );

    always #1 i_clk = ~i_clk;

    // No idling on either side through the middle of the run
    function automatic bit quiet_stretch();
        return board.noted >= 700 && board.noted < 1000;
    endfunction

    // Offer one byte, idling first at random, and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
        int gap;
        gap = 0;
        if (!quiet_stretch() && $urandom_range(99) < 9)
            gap = 1;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push              <= 1'b1;
        i_data_byte       <= b;
        i_first_in_buffer <= f;
        i_last_in_buffer  <= l;
        do @(posedge i_clk); while (full);
        board.note_byte(b, f, l);
    endtask

    // Send the staged buffer bytes, flagging its first and last byte as asked
    task automatic send_frame(input logic f, input logic l);
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], (i == 0) && f, (i == frame_q.size() - 1) && l);
        frame_q.delete();
    endtask

    // Stage one segment with random kind and content; optionally a too-short length
    task automatic add_segment(input bit short_len);
        logic [7:0]  lead;
        logic [23:0] len;
        logic [15:0] tag;
        int          hl;
        int          plen;
        case ($urandom_range(3))
            0:       lead = LEAD_SKIP;
            1:       lead = LEAD_TLONG;
            2:       lead = LEAD_UNTAG;
            default: lead = LEAD_TSHORT;
        endcase
        hl   = (lead == LEAD_TLONG) ? int'(HDR_LONG) : int'(HDR_SHORT);
        plen = ($urandom_range(24) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 12);
        if (lead == LEAD_TSHORT && plen > 251)
            plen = 251;
        len = short_len ? 24'($urandom_range(0, hl - 1)) : 24'(hl + plen);
        tag = 16'($urandom);
        frame_q.push_back(lead);
        if (lead == LEAD_TSHORT) begin
            frame_q.push_back(len[7:0]);
        end else begin
            frame_q.push_back(len[23:16]);
            frame_q.push_back(len[15:8]);
            frame_q.push_back(len[7:0]);
        end
        if (lead == LEAD_TLONG || lead == LEAD_TSHORT) begin
            frame_q.push_back(tag[7:0]);
            frame_q.push_back(tag[15:8]);
        end
        if (!short_len)
            repeat (plen) frame_q.push_back(8'($urandom));
    endtask

    // Check each popped label; drive pop with random idling and one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            seen.role  = t_role'(o_byte_role);
            seen.kind  = t_kind'(o_segment_kind);
            seen.tag   = o_segment_tag;
            seen.poff  = o_payload_offset;
            seen.done  = o_segment_done;
            seen.eidx  = o_entry_index;
            seen.eoff  = o_entry_offset;
            seen.boff  = o_buffer_offset;
            seen.trunc = o_truncated;
            board.check_label(seen);
        end
        if (!hold_done && board.noted >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= quiet_stretch() || ($urandom_range(99) >= 9);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("** marker_segment_deframer: FAILED **");
            $finish;
        end
    end

    initial begin
        int  roll;
        int  tail;
        int  cut;
        bit  first_flag;
        bit  last_flag;
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // End marker, then a byte ignored after it
        frame_q = '{LEAD_END, 8'h55};
        send_frame(1'b1, 1'b0);
        // Unknown lead byte, then a byte ignored after the error
        frame_q = '{8'h00, LEAD_TLONG};
        send_frame(1'b1, 1'b0);
        // Length equal to header, tagged long and short segments, short length error
        frame_q = '{LEAD_SKIP, 8'h00, 8'h00, 8'h04,
                    LEAD_TLONG, 8'h00, 8'h00, 8'h06, 8'h34, 8'h12,
                    LEAD_TSHORT, 8'h05, 8'h41, 8'h42, 8'hFF,
                    LEAD_TSHORT, 8'h03, 8'h77};
        send_frame(1'b1, 1'b0);
        // Buffer ends after a segment header, before its payload
        frame_q = '{LEAD_UNTAG, 8'h00, 8'h01, 8'h00};
        send_frame(1'b1, 1'b1);
        // Single-byte buffer with a bad lead byte
        frame_q = '{8'hFF};
        send_frame(1'b1, 1'b1);

        // Random buffers: mostly well-formed segment chains, some noise
        while (board.noted < ITEM_TARGET) begin
            roll       = $urandom_range(99);
            first_flag = ($urandom_range(9) != 0);
            if (roll < 80) begin
                repeat ($urandom_range(1, 4)) add_segment(1'b0);
                tail = $urandom_range(9);
                if (tail < 6) begin
                    frame_q.push_back(LEAD_END);
                    repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom));
                    last_flag = $urandom_range(1);
                end else if (tail < 8) begin
                    last_flag = 1'b1;
                end else begin
                    cut = $urandom_range(1, frame_q.size() - 1);
                    while (frame_q.size() > cut)
                        void'(frame_q.pop_back());
                    last_flag = ($urandom_range(9) < 7);
                end
            end else begin
                case ($urandom_range(2))
                    0: repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
                    1: begin
                        if ($urandom_range(1))
                            add_segment(1'b0);
                        add_segment(1'b1);
                    end
                    default: begin
                        frame_q.push_back(8'($urandom_range(LEAD_END, LEAD_TSHORT)));
                        repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
                    end
                endcase
                last_flag = $urandom_range(1);
            end
            send_frame(first_flag, last_flag);
        end
        push <= 1'b0;

        // Drain the pending labels, then give the block time to show extras
        while (board.label_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.fails == 0 && board.label_q.size() == 0)
            $display("** marker_segment_deframer: PASSED **");
        else
            $display("** marker_segment_deframer: FAILED **");
        $finish;
    end

endmodule
